>>> hdl/apci_pkg.sv
// shared types, codes and constants of the ata pio command issuer
// no dependencies
package apci_pkg;

	localparam logic [2:0] ACT_WRITE  = 3'd0;
	localparam logic [2:0] ACT_DUMMY  = 3'd1;
	localparam logic [2:0] ACT_BUSY   = 3'd2;
	localparam logic [2:0] ACT_DRQ    = 3'd3;
	localparam logic [2:0] ACT_PACKET = 3'd4;
	localparam logic [2:0] ACT_DATA   = 3'd5;
	localparam logic [2:0] ACT_ERROR  = 3'd6;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_DRIVE = 2'd1;
	localparam logic [1:0] ST_RANGE    = 2'd2;
	localparam logic [1:0] ST_ATAPI_WR = 2'd3;

	localparam logic [2:0] CFG_PRESENT  = 3'd0;
	localparam logic [2:0] CFG_ATAPI    = 3'd1;
	localparam logic [2:0] CFG_LBA_CAP  = 3'd2;
	localparam logic [2:0] CFG_POSITION = 3'd3;
	localparam logic [2:0] CFG_SIZE_0   = 3'd4;
	localparam logic [2:0] CFG_SIZE_1   = 3'd5;
	localparam logic [2:0] CFG_SIZE_2   = 3'd6;
	localparam logic [2:0] CFG_SIZE_3   = 3'd7;

	// floor(x / 63) = (x * RECIP_63) >> 34 for every x below 2^28
	localparam logic [28:0] RECIP_63 = 29'd272696337;
	localparam int          RECIP_SH = 34;

	localparam logic [4:0] STEP_ATA_LAST   = 5'd20;
	localparam logic [4:0] STEP_ATAPI_LAST = 5'd17;
	localparam logic [4:0] STEP_SEL        = 5'd2;
	localparam logic [4:0] STEP_COUNT      = 5'd15;

	typedef enum logic [1:0] {
		K_ATA,
		K_ATAPI,
		K_ERR
	} kind_t;

	typedef struct packed {
		logic [3:0]  present;
		logic [3:0]  atapi;
		logic [3:0]  lba_cap;
		logic [7:0]  position;
		logic [31:0] size0;
		logic [31:0] size1;
		logic [31:0] size2;
		logic [31:0] size3;
	} cfg_t;

	typedef struct packed {
		kind_t       kind;
		logic [1:0]  status;
		logic        wr;
		logic        ch;
		logic        slave;
		logic        lba_cap;
		logic [31:0] lba;
		logic [7:0]  cnt;
	} chk_t;

	typedef struct packed {
		kind_t       kind;
		logic [1:0]  status;
		logic        ch;
		logic        slave;
		logic        lba48;
		logic [31:0] lba;
		logic [7:0]  cnt;
		logic [7:0]  sel;
		logic [7:0]  cmd;
		logic [7:0]  b0;
		logic [7:0]  b1;
		logic [7:0]  b2;
	} desc_t;

endpackage

>>> hdl/apci_chk.sv
// input register and request checks (stages one and two)
// depends on apci_pkg
module apci_chk (
	input  logic                clk,
	input  logic                arst_n,
	input  apci_pkg::cfg_t      cfg,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                is_write,
	input  logic [7:0]          drive_slot,
	input  logic [31:0]         start_lba,
	input  logic [7:0]          sector_count,
	output logic                o_vld,
	input  logic                o_rdy,
	output apci_pkg::chk_t      o_chk
);
	logic        vld_s1, vld_s2, rdy_s1, rdy_s2;
	logic        wr_s1;
	logic [7:0]  slot_s1, cnt_s1;
	logic [31:0] lba_s1;
	apci_pkg::chk_t chk_s2, chk_d;
	logic [1:0]  sl;
	logic [31:0] size_sel, end_lba;

	assign rdy_s2   = !vld_s2 || o_rdy;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			wr_s1   <= is_write;
			slot_s1 <= drive_slot;
			lba_s1  <= start_lba;
			cnt_s1  <= sector_count;
		end
		if (rdy_s2 && vld_s1) chk_s2 <= chk_d;
	end

	always_comb begin
		sl = slot_s1[1:0];
		case (sl)
			2'd0:    size_sel = cfg.size0;
			2'd1:    size_sel = cfg.size1;
			2'd2:    size_sel = cfg.size2;
			default: size_sel = cfg.size3;
		endcase
		end_lba = lba_s1 + {24'd0, cnt_s1} - 32'd1;
		chk_d.wr      = wr_s1;
		chk_d.ch      = cfg.position[{sl, 1'b0}];
		chk_d.slave   = cfg.position[{sl, 1'b1}];
		chk_d.lba_cap = cfg.lba_cap[sl];
		chk_d.lba     = lba_s1;
		chk_d.cnt     = cnt_s1;
		chk_d.kind    = apci_pkg::K_ERR;
		if (slot_s1[7:2] != 6'd0 || !cfg.present[sl])
			chk_d.status = apci_pkg::ST_NO_DRIVE;
		else if (end_lba > size_sel)
			chk_d.status = apci_pkg::ST_RANGE;
		else if (cfg.atapi[sl] && wr_s1)
			chk_d.status = apci_pkg::ST_ATAPI_WR;
		else begin
			chk_d.status = apci_pkg::ST_OK;
			chk_d.kind   = cfg.atapi[sl] ? apci_pkg::K_ATAPI : apci_pkg::K_ATA;
		end
	end

	assign o_vld = vld_s2;
	assign o_chk = chk_s2;

endmodule

>>> hdl/apci_addr.sv
// chs split by reciprocal multiply and taskfile byte build (stages three and four)
// depends on apci_pkg
module apci_addr (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            i_vld,
	output logic            i_rdy,
	input  apci_pkg::chk_t  i_chk,
	output logic            o_vld,
	input  logic            o_rdy,
	output apci_pkg::desc_t o_desc
);
	logic            vld_s3, vld_s4, rdy_s3, rdy_s4;
	apci_pkg::chk_t  chk_s3;
	logic [22:0]     q_s3;
	logic [56:0]     prod;
	apci_pkg::desc_t desc_s4, desc_d;
	logic [28:0]     q63;
	logic [5:0]      rem;
	logic [3:0]      head;
	logic            mode48, chs;

	assign rdy_s4 = !vld_s4 || o_rdy;
	assign rdy_s3 = !vld_s3 || rdy_s4;
	assign i_rdy  = rdy_s3;
	assign prod   = i_chk.lba[27:0] * apci_pkg::RECIP_63;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy_s3) vld_s3 <= i_vld;
			if (rdy_s4) vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && i_vld) begin
			chk_s3 <= i_chk;
			q_s3   <= prod[56:apci_pkg::RECIP_SH];
		end
		if (rdy_s4 && vld_s3) desc_s4 <= desc_d;
	end

	always_comb begin
		q63    = {q_s3, 6'd0} - {6'd0, q_s3};
		rem    = 6'(chk_s3.lba[28:0] - q63);
		mode48 = chk_s3.lba[31:28] != 4'd0;
		chs    = !mode48 && !chk_s3.lba_cap;
		desc_d.kind   = chk_s3.kind;
		desc_d.status = chk_s3.status;
		desc_d.ch     = chk_s3.ch;
		desc_d.slave  = chk_s3.slave;
		desc_d.lba48  = mode48;
		desc_d.lba    = chk_s3.lba;
		desc_d.cnt    = chk_s3.cnt;
		if (chs) begin
			desc_d.b0 = {2'd0, rem} + 8'd1;
			desc_d.b1 = q_s3[11:4];
			desc_d.b2 = q_s3[19:12];
			head      = q_s3[3:0];
		end else begin
			desc_d.b0 = chk_s3.lba[7:0];
			desc_d.b1 = chk_s3.lba[15:8];
			desc_d.b2 = chk_s3.lba[23:16];
			head      = mode48 ? 4'd0 : chk_s3.lba[27:24];
		end
		desc_d.sel = (chs ? 8'hA0 : 8'hE0) | {3'd0, chk_s3.slave, head};
		if (mode48) desc_d.cmd = chk_s3.wr ? 8'h34 : 8'h24;
		else        desc_d.cmd = chk_s3.wr ? 8'h30 : 8'h20;
	end

	assign o_vld  = vld_s4;
	assign o_desc = desc_s4;

endmodule

>>> hdl/apci_seq.sv
// access sequencer: walks one request descriptor, one word per cycle while out_stall is low, into the output register
// depends on apci_pkg
module apci_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            i_vld,
	output logic            i_rdy,
	input  apci_pkg::desc_t i_desc,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [2:0]      action,
	output logic            channel,
	output logic            port_block,
	output logic [2:0]      reg_offset,
	output logic [15:0]     reg_data,
	output logic [1:0]      status,
	output logic            last
);
	logic            busy_q, ov_q;
	logic [4:0]      step_q;
	apci_pkg::desc_t d_q;
	logic            emit, load, is_last;
	logic [2:0]      act, off;
	logic            blk;
	logic [15:0]     dat;
	logic [4:0]      step_nx;

	assign emit  = busy_q && (!ov_q || !out_stall);
	assign load  = i_vld && (!busy_q || (emit && is_last));
	assign i_rdy = !busy_q || (emit && is_last);

	always_comb begin
		case (d_q.kind)
			apci_pkg::K_ERR:   is_last = 1'b1;
			apci_pkg::K_ATAPI: is_last = step_q == apci_pkg::STEP_ATAPI_LAST;
			default:           is_last = step_q == apci_pkg::STEP_ATA_LAST;
		endcase
		if (d_q.kind == apci_pkg::K_ATA && step_q == apci_pkg::STEP_SEL && !d_q.lba48)
			step_nx = apci_pkg::STEP_COUNT;
		else
			step_nx = step_q + 5'd1;
	end

	always_comb begin
		act = apci_pkg::ACT_WRITE;
		blk = 1'b0;
		off = 3'd0;
		dat = 16'd0;
		case (d_q.kind)
			apci_pkg::K_ERR: act = apci_pkg::ACT_ERROR;
			apci_pkg::K_ATAPI: begin
				case (step_q)
					5'd0: begin blk = 1'b1; off = 3'd2; end
					5'd1: begin off = 3'd6; dat = {11'd0, d_q.slave, 4'd0}; end
					5'd2, 5'd3, 5'd4, 5'd5: begin
						act = apci_pkg::ACT_DUMMY; blk = 1'b1; off = 3'd2;
					end
					5'd6: off = 3'd1;
					5'd7: off = 3'd4;
					5'd8: begin off = 3'd5; dat = 16'h0008; end
					5'd9: begin off = 3'd7; dat = 16'h00A0; end
					5'd10: begin act = apci_pkg::ACT_DRQ; off = 3'd7; end
					5'd11: begin act = apci_pkg::ACT_PACKET; dat = 16'h00A8; end
					5'd12: begin
						act = apci_pkg::ACT_PACKET; dat = {d_q.lba[23:16], d_q.lba[31:24]};
					end
					5'd13: begin
						act = apci_pkg::ACT_PACKET; dat = {d_q.lba[7:0], d_q.lba[15:8]};
					end
					5'd15: begin act = apci_pkg::ACT_PACKET; dat = {d_q.cnt, 8'd0}; end
					5'd14, 5'd16: act = apci_pkg::ACT_PACKET;
					default: begin act = apci_pkg::ACT_DATA; dat = {8'd0, d_q.cnt}; end
				endcase
			end
			default: begin
				case (step_q)
					5'd0, 5'd5, 5'd8, 5'd11, 5'd14: begin
						blk = 1'b1; off = 3'd2; dat = 16'h0002;
					end
					5'd3, 5'd6, 5'd9, 5'd12: begin
						blk = 1'b1; off = 3'd2; dat = 16'h0082;
					end
					5'd1: begin act = apci_pkg::ACT_BUSY; off = 3'd7; end
					5'd2: begin off = 3'd6; dat = {8'd0, d_q.sel}; end
					5'd4: off = 3'd2;
					5'd7: begin off = 3'd3; dat = {8'd0, d_q.lba[31:24]}; end
					5'd10: off = 3'd4;
					5'd13: off = 3'd5;
					5'd15: begin off = 3'd2; dat = {8'd0, d_q.cnt}; end
					5'd16: begin off = 3'd3; dat = {8'd0, d_q.b0}; end
					5'd17: begin off = 3'd4; dat = {8'd0, d_q.b1}; end
					5'd18: begin off = 3'd5; dat = {8'd0, d_q.b2}; end
					5'd19: begin off = 3'd7; dat = {8'd0, d_q.cmd}; end
					default: begin act = apci_pkg::ACT_DATA; dat = {8'd0, d_q.cnt}; end
				endcase
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ov_q   <= 1'b0;
			step_q <= 5'd0;
		end else begin
			if (emit) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
			if (load) begin
				busy_q <= 1'b1;
				step_q <= 5'd0;
			end else if (emit) begin
				if (is_last) busy_q <= 1'b0;
				step_q <= step_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) d_q <= i_desc;
		if (emit) begin
			action     <= act;
			channel    <= (d_q.kind == apci_pkg::K_ERR) ? 1'b0 : d_q.ch;
			port_block <= blk;
			reg_offset <= off;
			reg_data   <= dat;
			status     <= d_q.status;
			last       <= is_last;
		end
	end

	assign out_valid = ov_q;

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && action == apci_pkg::ACT_ERROR |-> last)
		else $error("error word without last");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> step_q <= apci_pkg::STEP_ATA_LAST)
		else $error("step counter out of range");
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		emit && is_last && !load |=> !busy_q)
		else $error("sequencer stays busy after last word");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !busy_q || is_last)
		else $error("descriptor loaded over a running request");

endmodule

>>> hdl/ata_pio_command_issuer_unit.sv
// top level of the ata pio command issuer: config registers, checks, address build, sequencer
// depends on apci_pkg, apci_chk, apci_addr, apci_seq
//
// channel | handshake            | payload
// in      | in_valid / in_stall  | is_write, drive_slot, start_lba, sector_count
// out     | out_valid / out_stall| action, channel, port_block, reg_offset, reg_data, status, last
// cfg     | cfg_we               | cfg_index, cfg_data
//
// a request passes four register stages (input, checks, divide by 63, byte build)
// and then the sequencer sends one word per cycle while out_stall is low: 1 word for an
// error, 9 for lba28/chs, 21 for lba48, 18 for atapi
// new requests fill the front stages while the sequencer runs
// reset clears all valid bits, the sequencer and the config registers
// out_stall holds the output word and backs up through the stages to in_stall
module ata_pio_command_issuer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        is_write,
	input  logic [7:0]  drive_slot,
	input  logic [31:0] start_lba,
	input  logic [7:0]  sector_count,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  action,
	output logic        channel,
	output logic        port_block,
	output logic [2:0]  reg_offset,
	output logic [15:0] reg_data,
	output logic [1:0]  status,
	output logic        last
);
	// slot configuration; the user must write it only while idle, the block does not enforce this
	apci_pkg::cfg_t  cfg_q;
	// check stage to address stage
	logic            chk_vld, chk_rdy;
	apci_pkg::chk_t  chk;
	// address stage to sequencer
	logic            desc_vld, desc_rdy;
	apci_pkg::desc_t desc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				apci_pkg::CFG_PRESENT:  cfg_q.present  <= cfg_data[3:0];
				apci_pkg::CFG_ATAPI:    cfg_q.atapi    <= cfg_data[3:0];
				apci_pkg::CFG_LBA_CAP:  cfg_q.lba_cap  <= cfg_data[3:0];
				apci_pkg::CFG_POSITION: cfg_q.position <= cfg_data[7:0];
				apci_pkg::CFG_SIZE_0:   cfg_q.size0    <= cfg_data;
				apci_pkg::CFG_SIZE_1:   cfg_q.size1    <= cfg_data;
				apci_pkg::CFG_SIZE_2:   cfg_q.size2    <= cfg_data;
				default:                cfg_q.size3    <= cfg_data;
			endcase
		end
	end

	// slot checks and error code
	apci_chk u_chk (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.in_valid(in_valid), .in_stall(in_stall),
		.is_write(is_write), .drive_slot(drive_slot),
		.start_lba(start_lba), .sector_count(sector_count),
		.o_vld(chk_vld), .o_rdy(chk_rdy), .o_chk(chk)
	);

	// chs split and taskfile bytes
	apci_addr u_addr (
		.clk(clk), .arst_n(arst_n),
		.i_vld(chk_vld), .i_rdy(chk_rdy), .i_chk(chk),
		.o_vld(desc_vld), .o_rdy(desc_rdy), .o_desc(desc)
	);

	// register access sequence
	apci_seq u_seq (
		.clk(clk), .arst_n(arst_n),
		.i_vld(desc_vld), .i_rdy(desc_rdy), .i_desc(desc),
		.out_valid(out_valid), .out_stall(out_stall),
		.action(action), .channel(channel), .port_block(port_block),
		.reg_offset(reg_offset), .reg_data(reg_data),
		.status(status), .last(last)
	);

endmodule

>>> bench/tb_top.sv
// self-checking bench for the ata pio command issuer: random and directed requests,
// expected register access words from an in-bench model, compared word by word
// depends on apci_pkg and ata_pio_command_issuer_unit
module tb_top;

	typedef struct packed {
		logic [2:0]  action;
		logic        channel;
		logic        port_block;
		logic [2:0]  reg_offset;
		logic [15:0] reg_data;
		logic [1:0]  status;
		logic        last;
	} access_t;

	// expected access words plus the bench copy of the slot registers
	class access_board;
		access_t pending[$];
		logic [3:0] present, atapi, lba_cap;
		logic [7:0] position;
		logic [31:0] size[4];
		int errors;
		int words;
		int requests;

		function void clear_cfg();
			present = '0; atapi = '0; lba_cap = '0; position = '0;
			for (int i = 0; i < 4; i++) size[i] = '0;
		endfunction

		function void set_cfg(logic [2:0] idx, logic [31:0] val);
			case (idx)
				apci_pkg::CFG_PRESENT:  present = val[3:0];
				apci_pkg::CFG_ATAPI:    atapi = val[3:0];
				apci_pkg::CFG_LBA_CAP:  lba_cap = val[3:0];
				apci_pkg::CFG_POSITION: position = val[7:0];
				default:                size[idx[1:0]] = val;
			endcase
		endfunction

		function void push(logic [2:0] a, logic c, logic b, logic [2:0] o,
				logic [15:0] d, logic [1:0] s);
			access_t w;
			w = '{a, c, b, o, d, s, 1'b0};
			pending.push_back(w);
		endfunction

		function void push_high(logic c, logic [2:0] o, logic [7:0] d);
			push(apci_pkg::ACT_WRITE, c, 1'b1, 3'd2, 16'h82, apci_pkg::ST_OK);
			push(apci_pkg::ACT_WRITE, c, 1'b0, o, {8'h0, d}, apci_pkg::ST_OK);
			push(apci_pkg::ACT_WRITE, c, 1'b1, 3'd2, 16'h02, apci_pkg::ST_OK);
		endfunction

		// note one accepted request and queue its access words
		function void note_request(logic wr, logic [7:0] slot, logic [31:0] lba,
				logic [7:0] cnt);
			logic [1:0] err;
			logic ch, slave;
			logic [31:0] sect, base, cyl;
			logic [7:0] b0, b1, b2, head, sel, cmd;
			logic lba48;
			access_t w;
			requests++;
			err = apci_pkg::ST_OK;
			if (slot > 3 || !present[slot[1:0]]) err = apci_pkg::ST_NO_DRIVE;
			else if (lba + {24'h0, cnt} - 32'd1 > size[slot[1:0]]) err = apci_pkg::ST_RANGE;
			else if (atapi[slot[1:0]] && wr) err = apci_pkg::ST_ATAPI_WR;
			if (err != apci_pkg::ST_OK) begin
				push(apci_pkg::ACT_ERROR, 1'b0, 1'b0, 3'd0, 16'h0, err);
			end else begin
				ch = position[2 * slot];
				slave = position[2 * slot + 1];
				if (atapi[slot[1:0]]) begin
					push(apci_pkg::ACT_WRITE, ch, 1'b1, 3'd2, 16'h0, apci_pkg::ST_OK);
					push(apci_pkg::ACT_WRITE, ch, 1'b0, 3'd6, {11'h0, slave, 4'h0},
						apci_pkg::ST_OK);
					for (int i = 0; i < 4; i++)
						push(apci_pkg::ACT_DUMMY, ch, 1'b1, 3'd2, 16'h0, apci_pkg::ST_OK);
					push(apci_pkg::ACT_WRITE, ch, 1'b0, 3'd1, 16'h00, apci_pkg::ST_OK);
					push(apci_pkg::ACT_WRITE, ch, 1'b0, 3'd4, 16'h00, apci_pkg::ST_OK);
					push(apci_pkg::ACT_WRITE, ch, 1'b0, 3'd5, 16'h08, apci_pkg::ST_OK);
					push(apci_pkg::ACT_WRITE, ch, 1'b0, 3'd7, 16'hA0, apci_pkg::ST_OK);
					push(apci_pkg::ACT_DRQ, ch, 1'b0, 3'd7, 16'h0, apci_pkg::ST_OK);
					push(apci_pkg::ACT_PACKET, ch, 1'b0, 3'd0, 16'h00A8, apci_pkg::ST_OK);
					push(apci_pkg::ACT_PACKET, ch, 1'b0, 3'd0, {lba[23:16], lba[31:24]},
						apci_pkg::ST_OK);
					push(apci_pkg::ACT_PACKET, ch, 1'b0, 3'd0, {lba[7:0], lba[15:8]},
						apci_pkg::ST_OK);
					push(apci_pkg::ACT_PACKET, ch, 1'b0, 3'd0, 16'h0, apci_pkg::ST_OK);
					push(apci_pkg::ACT_PACKET, ch, 1'b0, 3'd0, {cnt, 8'h0}, apci_pkg::ST_OK);
					push(apci_pkg::ACT_PACKET, ch, 1'b0, 3'd0, 16'h0, apci_pkg::ST_OK);
				end else begin
					lba48 = lba >= 32'h1000_0000;
					if (lba48 || lba_cap[slot[1:0]]) begin
						b0 = lba[7:0]; b1 = lba[15:8]; b2 = lba[23:16];
						head = lba48 ? 8'h0 : {4'h0, lba[27:24]};
						sel = 8'hE0 | {3'b0, slave, 4'h0} | head;
					end else begin
						sect = lba % 63 + 1;
						base = lba - (sect - 1);
						cyl = (base / (16 * 63)) & 32'hFFFF;
						b0 = sect[7:0]; b1 = cyl[7:0]; b2 = cyl[15:8];
						head = 8'((base % (16 * 63)) / 63);
						sel = 8'hA0 | {3'b0, slave, 4'h0} | head;
					end
					cmd = lba48 ? (wr ? 8'h34 : 8'h24) : (wr ? 8'h30 : 8'h20);
					push(apci_pkg::ACT_WRITE, ch, 1'b1, 3'd2, 16'h02, apci_pkg::ST_OK);
					push(apci_pkg::ACT_BUSY, ch, 1'b0, 3'd7, 16'h0, apci_pkg::ST_OK);
					push(apci_pkg::ACT_WRITE, ch, 1'b0, 3'd6, {8'h0, sel}, apci_pkg::ST_OK);
					if (lba48) begin
						push_high(ch, 3'd2, 8'h0);
						push_high(ch, 3'd3, lba[31:24]);
						push_high(ch, 3'd4, 8'h0);
						push_high(ch, 3'd5, 8'h0);
					end
					push(apci_pkg::ACT_WRITE, ch, 1'b0, 3'd2, {8'h0, cnt}, apci_pkg::ST_OK);
					push(apci_pkg::ACT_WRITE, ch, 1'b0, 3'd3, {8'h0, b0}, apci_pkg::ST_OK);
					push(apci_pkg::ACT_WRITE, ch, 1'b0, 3'd4, {8'h0, b1}, apci_pkg::ST_OK);
					push(apci_pkg::ACT_WRITE, ch, 1'b0, 3'd5, {8'h0, b2}, apci_pkg::ST_OK);
					push(apci_pkg::ACT_WRITE, ch, 1'b0, 3'd7, {8'h0, cmd}, apci_pkg::ST_OK);
				end
				push(apci_pkg::ACT_DATA, ch, 1'b0, 3'd0, {8'h0, cnt}, apci_pkg::ST_OK);
			end
			w = pending.pop_back();
			w.last = 1'b1;
			pending.push_back(w);
		endfunction

		// compare one accepted access word with the oldest expectation
		function void check_access(access_t got);
			access_t exp_w;
			words++;
			if (pending.size() == 0) begin
				$error("unexpected word %p", got);
				errors++;
				return;
			end
			exp_w = pending.pop_front();
			if (got.action !== exp_w.action) begin
				$error("action exp %0d got %0d", exp_w.action, got.action); errors++;
			end
			if (got.channel !== exp_w.channel) begin
				$error("channel exp %0d got %0d", exp_w.channel, got.channel); errors++;
			end
			if (got.port_block !== exp_w.port_block) begin
				$error("port_block exp %0d got %0d", exp_w.port_block, got.port_block);
				errors++;
			end
			if (got.reg_offset !== exp_w.reg_offset) begin
				$error("reg_offset exp %0d got %0d", exp_w.reg_offset, got.reg_offset);
				errors++;
			end
			if (got.reg_data !== exp_w.reg_data) begin
				$error("reg_data exp %h got %h", exp_w.reg_data, got.reg_data); errors++;
			end
			if (got.status !== exp_w.status) begin
				$error("status exp %0d got %0d", exp_w.status, got.status); errors++;
			end
			if (got.last !== exp_w.last) begin
				$error("last exp %0d got %0d", exp_w.last, got.last); errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        is_write = 1'b0;
	logic [7:0]  drive_slot = '0;
	logic [31:0] start_lba = '0;
	logic [7:0]  sector_count = '0;
	logic        out_valid;
	logic        out_stall = 1'b1;
	logic [2:0]  action;
	logic        channel;
	logic        port_block;
	logic [2:0]  reg_offset;
	logic [15:0] reg_data;
	logic [1:0]  status;
	logic        last;

	access_board board;
	int send_idle_pct = 0;      // chance the sender leaves a gap before a request
	int recv_stall_pct = 0;     // chance the receiver stalls in a cycle
	bit hold_off = 1'b0;        // long receiver stall, to back up the pipeline
	int quiet_cycles = 0;

	localparam int WATCHDOG = 20000;

	always #10 clk = ~clk;

	ata_pio_command_issuer_unit DUT (.*);

	// receiver: random stall at the falling edge, sample at the rising edge
	always @(negedge clk) begin
		if (!arst_n) out_stall <= 1'b1;
		else out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_access('{action, channel, port_block, reg_offset, reg_data,
				status, last});
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > WATCHDOG) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		board.set_cfg(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// one request: optional gap, then hold valid until accepted
	task automatic send_request(logic wr, logic [7:0] slot, logic [31:0] lba,
			logic [7:0] cnt);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		is_write <= wr;
		drive_slot <= slot;
		start_lba <= lba;
		sector_count <= cnt;
		do @(posedge clk); while (in_stall);
		board.note_request(wr, slot, lba, cnt);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	// random request, mostly hitting present slots and legal ranges
	task automatic random_request();
		logic [7:0] slot;
		logic [31:0] lba;
		logic [7:0] cnt;
		int pick;
		slot = ($urandom_range(15) == 0) ? 8'($urandom) : 8'($urandom_range(3));
		cnt = 8'($urandom);
		pick = $urandom_range(9);
		if (pick < 3) lba = $urandom_range(32'h0FFF_FFFF);
		else if (pick < 5) lba = $urandom_range(4095);
		else if (pick < 8 && slot < 4) lba = $urandom_range(board.size[slot[1:0]]);
		else lba = $urandom;
		send_request(1'($urandom_range(1)), slot, lba, cnt);
	endtask

	task automatic random_config();
		write_reg(apci_pkg::CFG_PRESENT, ($urandom_range(3) == 0) ? $urandom : 32'hF);
		write_reg(apci_pkg::CFG_ATAPI, $urandom);
		write_reg(apci_pkg::CFG_LBA_CAP, $urandom);
		write_reg(apci_pkg::CFG_POSITION, $urandom);
		for (int i = 0; i < 4; i++)
			write_reg(3'(apci_pkg::CFG_SIZE_0 + i), ($urandom_range(3) == 0) ? $urandom
				: 32'hFFFF_FFFF - $urandom_range(1000));
	endtask

	initial begin
		board = new();
		board.clear_cfg();
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset values: every request refused as no drive
		send_request(1'b0, 8'd0, 32'd0, 8'd1);
		drain();

		// slots: 0 ata lba, 1 ata chs, 2 atapi, 3 absent; mixed channels and slave bits
		write_reg(apci_pkg::CFG_PRESENT, 32'h7);
		write_reg(apci_pkg::CFG_ATAPI, 32'h4);
		write_reg(apci_pkg::CFG_LBA_CAP, 32'h1);
		write_reg(apci_pkg::CFG_POSITION, 32'hB6);
		write_reg(apci_pkg::CFG_SIZE_0, 32'hFFFF_FFFF);
		write_reg(apci_pkg::CFG_SIZE_1, 32'h0FFF_FFFF);
		write_reg(apci_pkg::CFG_SIZE_2, 32'h0001_0000);
		write_reg(apci_pkg::CFG_SIZE_3, 32'hFFFF_FFFF);
		send_request(1'b0, 8'd0, 32'h0000_0000, 8'd1);     // lba28 low end
		send_request(1'b1, 8'd0, 32'h0FFF_FFFF, 8'd1);     // lba28 top
		send_request(1'b0, 8'd0, 32'h1000_0000, 8'd255);   // lba48 boundary
		send_request(1'b1, 8'd0, 32'hFFFF_FF00, 8'd255);   // lba48 top
		send_request(1'b0, 8'd0, 32'h0000_0000, 8'd0);     // zero count wraps to the top
		send_request(1'b0, 8'd0, 32'h0000_0005, 8'd0);     // zero count accepted
		send_request(1'b0, 8'd1, 32'd0, 8'd1);             // chs start
		send_request(1'b1, 8'd1, 32'h0FFF_FFFE, 8'd1);     // chs cylinder cut
		send_request(1'b0, 8'd1, 32'd1007, 8'd2);          // chs head/track edge
		send_request(1'b0, 8'd1, 32'h1234_5678, 8'd4);     // lba48 on chs slot: range fail
		send_request(1'b0, 8'd2, 32'h0000_ABCD, 8'd16);    // atapi read
		send_request(1'b1, 8'd2, 32'h0000_0010, 8'd1);     // atapi write refused
		send_request(1'b0, 8'd2, 32'h0001_0000, 8'd2);     // atapi out of range
		send_request(1'b0, 8'd3, 32'd0, 8'd1);             // absent slot
		send_request(1'b0, 8'd4, 32'd0, 8'd1);             // slot above three
		send_request(1'b1, 8'd255, 32'hFFFF_FFFF, 8'd255); // all ones
		drain();
		write_reg(apci_pkg::CFG_SIZE_1, 32'hFFFF_FFFF);
		send_request(1'b0, 8'd1, 32'hF000_0000, 8'd8);     // lba48 on a non-lba slot
		drain();

		// pressure: receiver holds off while requests keep coming
		hold_off = 1'b1;
		fork
			begin
				repeat (400) @(negedge clk);
				hold_off = 1'b0;
			end
			for (int i = 0; i < 12; i++) random_request();
		join
		drain();

		// random phases: sender idle 27 / receiver 69, swapped, then none
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 69 : 0;
			recv_stall_pct = (ph == 0) ? 69 : (ph == 1) ? 27 : 0;
			for (int cfgs = 0; cfgs < 3; cfgs++) begin
				random_config();
				for (int i = 0; i < 38; i++) random_request();
				drain();
			end
		end
		// extreme config: nothing present, then everything atapi
		write_reg(apci_pkg::CFG_PRESENT, 32'h0);
		for (int i = 0; i < 5; i++) random_request();
		drain();
		write_reg(apci_pkg::CFG_PRESENT, 32'hF);
		write_reg(apci_pkg::CFG_ATAPI, 32'hF);
		write_reg(apci_pkg::CFG_POSITION, 32'hFF);
		for (int i = 0; i < 10; i++) random_request();
		drain();

		$display("covered %0d requests and %0d access words over lba28, lba48, chs,",
			board.requests, board.words);
		$display("atapi and every refusal, under random gaps and stalls");
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

>>> ata_pio_command_issuer_unit.f
hdl/apci_pkg.sv
hdl/apci_chk.sv
hdl/apci_addr.sv
hdl/apci_seq.sv
hdl/ata_pio_command_issuer_unit.sv
bench/tb_top.sv
